// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge out of reset
`define TTI_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TTI_ASSERT(lbl, cond, msg)
`define TTI_ASSERT_IMP(lbl, ante, cons, msg)
`define TTI_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/tti_pkg.sv -----
package tti_pkg;

  localparam int TIME_BITS      = 48;
  localparam int COORD_BITS     = 32;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int MD_MAX_STEPS   = (TIME_BITS > COORD_BITS) ? TIME_BITS : COORD_BITS;
  localparam int MD_CNT_BITS    = $clog2(MD_MAX_STEPS + 1);

  typedef logic [TIME_BITS-1:0]  tkey_t;
  typedef logic [COORD_BITS-1:0] ckey_t;

  // stored entry, all fields as biased keys (sign bit flipped)
  typedef struct packed {
    tkey_t tkey;
    ckey_t x;
    ckey_t y;
    ckey_t z;
  } entry_t;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_BEFORE = 3'd1,
    ST_AFTER  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_STORED = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_MV_RD,
    S_MV_WR,
    S_END_CAP,
    S_Q_CAP0,
    S_Q_CAP1,
    S_MD_START,
    S_MD_WAIT,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  function automatic tkey_t t_flip(input tkey_t v);
    return {~v[TIME_BITS-1], v[TIME_BITS-2:0]};
  endfunction

  function automatic ckey_t c_flip(input ckey_t v);
    return {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
  endfunction

endpackage

// ----- sv/tti_mem.sv -----
module tti_mem #(
  parameter int DEPTH = tti_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output tti_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tti_pkg::entry_t wr_data
);

  tti_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/tti_muldiv.sv -----
// floor(a * b / d), with a * b < d * 2^COORD_BITS.
// Shift-add multiply, one bit of b per cycle, then restoring divide, one
// quotient bit per cycle.
module tti_muldiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tti_pkg::ckey_t        a_in,
  input  tti_pkg::tkey_t        b_in,
  input  tti_pkg::tkey_t        d_in,
  output logic                  done,
  output tti_pkg::ckey_t        q
);

  localparam int TB = tti_pkg::TIME_BITS;
  localparam int CB = tti_pkg::COORD_BITS;
  localparam int PW = TB + CB;
  localparam int NB = tti_pkg::MD_CNT_BITS;

  tti_pkg::md_state_t st_r, st_nxt;
  logic [NB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] a_r, a_nxt;
  logic [TB-1:0] b_r, b_nxt;
  logic [TB-1:0] d_r, d_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [TB-1:0] rem_r, rem_nxt;
  logic [CB-1:0] q_r, q_nxt;
  logic          done_r, done_nxt;
  logic [TB:0]   r2;
  logic [PW-1:0] addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= tti_pkg::MD_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    d_r   <= d_nxt;
    p_r   <= p_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    p_nxt    = p_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    addend   = b_r[TB-1] ? PW'(a_r) : '0;
    r2       = {rem_r, p_r[CB-1]};
    unique case (st_r)
      tti_pkg::MD_IDLE: begin
        if (start) begin
          a_nxt   = a_in;
          b_nxt   = b_in;
          d_nxt   = d_in;
          p_nxt   = '0;
          cnt_nxt = NB'(TB);
          st_nxt  = tti_pkg::MD_MUL;
        end
      end
      tti_pkg::MD_MUL: begin
        p_nxt   = {p_r[PW-2:0], 1'b0} + addend;
        b_nxt   = {b_r[TB-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == NB'(1)) begin
          // upper part is already below d since the quotient fits CB bits
          rem_nxt = p_nxt[PW-1:CB];
          cnt_nxt = NB'(CB);
          st_nxt  = tti_pkg::MD_DIV;
        end
      end
      tti_pkg::MD_DIV: begin
        p_nxt   = {p_r[PW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (r2 >= {1'b0, d_r}) begin
          rem_nxt = TB'(r2 - {1'b0, d_r});
          q_nxt   = {q_r[CB-2:0], 1'b1};
        end else begin
          rem_nxt = r2[TB-1:0];
          q_nxt   = {q_r[CB-2:0], 1'b0};
        end
        if (cnt_r == NB'(1)) begin
          done_nxt = 1'b1;
          st_nxt   = tti_pkg::MD_IDLE;
        end
      end
      default: st_nxt = tti_pkg::MD_IDLE;
    endcase
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- sv/trajectory_time_interpolator.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_opcode, in_sample_time, in_pos_x/y/z
// out      output     out_valid / out_stall out_x/y/z, out_status, out_in_span,
//                                            out_box_min_x/y/z, out_box_max_x/y/z
//
// One item at a time. Search: each probe of the time table is a read, then a
//   compare; about ceil(log2(n+1)) probes for n stored points (one read port).
// Add: search, move each later-timed entry up one slot (read, write), store.
// Query: search, read the two neighbouring points, then each axis in turn in
//   the shared serial multiply/divide unit.
// Reset (rst_n low, synchronous) clears count, span and box; table contents
//   are never cleared, only the first count entries are read.
// A result waiting under out_stall does not block the next accept; the block
//   only stalls the input while an item is in progress.
`include "assert_macros.svh"

module trajectory_time_interpolator #(
  parameter int MAX_POINTS = tti_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_opcode,
  input  logic signed [tti_pkg::TIME_BITS-1:0]   in_sample_time,
  input  logic signed [tti_pkg::COORD_BITS-1:0]  in_pos_x,
  input  logic signed [tti_pkg::COORD_BITS-1:0]  in_pos_y,
  input  logic signed [tti_pkg::COORD_BITS-1:0]  in_pos_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_x,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_y,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_z,
  output logic [2:0]                             out_status,
  output logic                                   out_in_span,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_box_min_x,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_box_min_y,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_box_min_z,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_box_max_x,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_box_max_y,
  output logic signed [tti_pkg::COORD_BITS-1:0]  out_box_max_z
);

  localparam int CW = $clog2(MAX_POINTS + 1);  // count, holds MAX_POINTS
  localparam int AW = $clog2(MAX_POINTS);      // table address

  // control state
  tti_pkg::ctl_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  tti_pkg::tkey_t      early_r, early_nxt;   // earliest stored time key
  tti_pkg::tkey_t      late_r, late_nxt;     // latest stored time key
  tti_pkg::ckey_t      box_lo_r [3];
  tti_pkg::ckey_t      box_lo_nxt [3];
  tti_pkg::ckey_t      box_hi_r [3];
  tti_pkg::ckey_t      box_hi_nxt [3];
  logic                out_valid_r, out_valid_nxt;

  // per-item work registers
  tti_pkg::op_t        op_r, op_nxt;
  tti_pkg::entry_t     new_r, new_nxt;       // incoming point / query time
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [CW-1:0]       mid_r, mid_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  tti_pkg::entry_t     e0_r, e0_nxt;
  tti_pkg::entry_t     e1_r, e1_nxt;
  tti_pkg::tkey_t      num_r, num_nxt;
  tti_pkg::tkey_t      den_r, den_nxt;
  logic [1:0]          k_r, k_nxt;
  tti_pkg::ckey_t      res_r [3];
  tti_pkg::ckey_t      res_nxt [3];
  tti_pkg::status_t    stat_r, stat_nxt;
  logic                span_r, span_nxt;

  // output payload registers
  tti_pkg::ckey_t      ox_r [3];
  tti_pkg::ckey_t      ox_nxt [3];
  tti_pkg::ckey_t      omin_r [3];
  tti_pkg::ckey_t      omin_nxt [3];
  tti_pkg::ckey_t      omax_r [3];
  tti_pkg::ckey_t      omax_nxt [3];
  tti_pkg::status_t    ostat_r, ostat_nxt;
  logic                ospan_r, ospan_nxt;

  // table port
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  tti_pkg::entry_t     rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  tti_pkg::entry_t     wr_data;

  // multiply/divide unit
  logic                md_start;
  tti_pkg::ckey_t      md_a;
  logic                md_done;
  tti_pkg::ckey_t      md_q;

  logic                in_acc;
  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid_c;
  tti_pkg::ckey_t      newc [3];
  tti_pkg::ckey_t      p0;
  tti_pkg::ckey_t      p1;

  tti_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tti_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a_in  (md_a),
    .b_in  (num_r),
    .d_in  (den_r),
    .done  (md_done),
    .q     (md_q)
  );

  assign in_stall = (state_r != tti_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c    = mid_sum[CW:1];
  assign newc[0]  = new_r.x;
  assign newc[1]  = new_r.y;
  assign newc[2]  = new_r.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tti_pkg::S_IDLE;
      count_r     <= '0;
      early_r     <= '1;
      late_r      <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        box_lo_r[a] <= '1;
        box_hi_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      early_r     <= early_nxt;
      late_r      <= late_nxt;
      out_valid_r <= out_valid_nxt;
      box_lo_r    <= box_lo_nxt;
      box_hi_r    <= box_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    new_r   <= new_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    j_r     <= j_nxt;
    e0_r    <= e0_nxt;
    e1_r    <= e1_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    k_r     <= k_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
    span_r  <= span_nxt;
    ox_r    <= ox_nxt;
    omin_r  <= omin_nxt;
    omax_r  <= omax_nxt;
    ostat_r <= ostat_nxt;
    ospan_r <= ospan_nxt;
  end

  // coordinate pair for the axis being interpolated
  always_comb begin
    case (k_r)
      2'd0:    begin p0 = e0_r.x; p1 = e1_r.x; end
      2'd1:    begin p0 = e0_r.y; p1 = e1_r.y; end
      default: begin p0 = e0_r.z; p1 = e1_r.z; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    early_nxt     = early_r;
    late_nxt      = late_r;
    box_lo_nxt    = box_lo_r;
    box_hi_nxt    = box_hi_r;
    op_nxt        = op_r;
    new_nxt       = new_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    j_nxt         = j_r;
    e0_nxt        = e0_r;
    e1_nxt        = e1_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    span_nxt      = span_r;
    ox_nxt        = ox_r;
    omin_nxt      = omin_r;
    omax_nxt      = omax_r;
    ostat_nxt     = ostat_r;
    ospan_nxt     = ospan_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = j_r[AW-1:0];
    wr_data       = rd_data;
    md_start      = 1'b0;
    md_a          = (p1 >= p0) ? p1 - p0 : p0 - p1;

    unique case (state_r)
      tti_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt       = tti_pkg::op_t'(in_opcode);
          new_nxt.tkey = tti_pkg::t_flip(in_sample_time);
          new_nxt.x    = tti_pkg::c_flip(in_pos_x);
          new_nxt.y    = tti_pkg::c_flip(in_pos_y);
          new_nxt.z    = tti_pkg::c_flip(in_pos_z);
          lo_nxt       = '0;
          hi_nxt       = count_r;
          span_nxt     = 1'b0;
          for (int a = 0; a < 3; a++) res_nxt[a] = tti_pkg::c_flip('0);
          state_nxt    = tti_pkg::S_SRCH;
          if (tti_pkg::op_t'(in_opcode) == tti_pkg::OP_ADD) begin
            if (count_r == CW'(MAX_POINTS)) begin
              stat_nxt  = tti_pkg::ST_FULL;
              state_nxt = tti_pkg::S_DONE;
            end
          end else begin
            span_nxt = (new_nxt.tkey >= early_r) && (new_nxt.tkey <= late_r);
            if (count_r == '0) begin
              stat_nxt  = tti_pkg::ST_EMPTY;
              state_nxt = tti_pkg::S_DONE;
            end
          end
        end
      end

      // upper bound: first entry whose time is above the key
      tti_pkg::S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid_c[AW-1:0];
          mid_nxt   = mid_c;
          state_nxt = tti_pkg::S_SRCH_CMP;
        end else if (op_r == tti_pkg::OP_ADD) begin
          j_nxt     = count_r;
          state_nxt = tti_pkg::S_MV_RD;
        end else if (lo_r == '0) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          stat_nxt  = tti_pkg::ST_BEFORE;
          state_nxt = tti_pkg::S_END_CAP;
        end else if (lo_r == count_r) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(count_r - CW'(1));
          stat_nxt  = tti_pkg::ST_AFTER;
          state_nxt = tti_pkg::S_END_CAP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(lo_r - CW'(1));
          state_nxt = tti_pkg::S_Q_CAP0;
        end
      end

      tti_pkg::S_SRCH_CMP: begin
        if (rd_data.tkey > new_r.tkey) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + CW'(1);
        end
        state_nxt = tti_pkg::S_SRCH;
      end

      // move later entries up one slot, from the top down
      tti_pkg::S_MV_RD: begin
        if (j_r > lo_r) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(j_r - CW'(1));
          state_nxt = tti_pkg::S_MV_WR;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = lo_r[AW-1:0];
          wr_data   = new_r;
          count_nxt = count_r + CW'(1);
          if (new_r.tkey < early_r) early_nxt = new_r.tkey;
          if (new_r.tkey > late_r) late_nxt = new_r.tkey;
          for (int a = 0; a < 3; a++) begin
            if (newc[a] < box_lo_r[a]) box_lo_nxt[a] = newc[a];
            if (newc[a] > box_hi_r[a]) box_hi_nxt[a] = newc[a];
          end
          stat_nxt  = tti_pkg::ST_STORED;
          state_nxt = tti_pkg::S_DONE;
        end
      end

      tti_pkg::S_MV_WR: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[AW-1:0];
        wr_data   = rd_data;
        j_nxt     = j_r - CW'(1);
        state_nxt = tti_pkg::S_MV_RD;
      end

      tti_pkg::S_END_CAP: begin
        res_nxt[0] = rd_data.x;
        res_nxt[1] = rd_data.y;
        res_nxt[2] = rd_data.z;
        state_nxt  = tti_pkg::S_DONE;
      end

      tti_pkg::S_Q_CAP0: begin
        e0_nxt    = rd_data;
        rd_en     = 1'b1;
        rd_addr   = lo_r[AW-1:0];
        state_nxt = tti_pkg::S_Q_CAP1;
      end

      tti_pkg::S_Q_CAP1: begin
        e1_nxt    = rd_data;
        num_nxt   = new_r.tkey - e0_r.tkey;
        den_nxt   = rd_data.tkey - e0_r.tkey;
        k_nxt     = 2'd0;
        state_nxt = tti_pkg::S_MD_START;
      end

      tti_pkg::S_MD_START: begin
        md_start  = 1'b1;
        state_nxt = tti_pkg::S_MD_WAIT;
      end

      // step is truncated toward zero: apply magnitude with the sign of p1-p0
      tti_pkg::S_MD_WAIT: begin
        if (md_done) begin
          res_nxt[k_r] = (p1 >= p0) ? p0 + md_q : p0 - md_q;
          if (k_r == 2'd2) begin
            stat_nxt  = tti_pkg::ST_INTERP;
            state_nxt = tti_pkg::S_DONE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = tti_pkg::S_MD_START;
          end
        end
      end

      tti_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          ox_nxt        = res_r;
          omin_nxt      = box_lo_r;
          omax_nxt      = box_hi_r;
          ostat_nxt     = stat_r;
          ospan_nxt     = span_r;
          state_nxt     = tti_pkg::S_IDLE;
        end
      end

      default: state_nxt = tti_pkg::S_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_x         = tti_pkg::c_flip(ox_r[0]);
  assign out_y         = tti_pkg::c_flip(ox_r[1]);
  assign out_z         = tti_pkg::c_flip(ox_r[2]);
  assign out_status    = ostat_r;
  assign out_in_span   = ospan_r;
  assign out_box_min_x = tti_pkg::c_flip(omin_r[0]);
  assign out_box_min_y = tti_pkg::c_flip(omin_r[1]);
  assign out_box_min_z = tti_pkg::c_flip(omin_r[2]);
  assign out_box_max_x = tti_pkg::c_flip(omax_r[0]);
  assign out_box_max_y = tti_pkg::c_flip(omax_r[1]);
  assign out_box_max_z = tti_pkg::c_flip(omax_r[2]);

  `TTI_ASSERT(a_count_range, count_r <= CW'(MAX_POINTS), "point count above table size")
  `TTI_ASSERT_NXT(a_count_step, 1'b1, (count_r - $past(count_r)) <= CW'(1), "count jumped")
  `TTI_ASSERT(a_span_valid, (count_r != '0) == (early_r <= late_r), "span disagrees with count")
  `TTI_ASSERT_IMP(a_box_order, count_r != '0, box_lo_r[0] <= box_hi_r[0], "x box inverted")
  `TTI_ASSERT_IMP(a_md_done, md_done, state_r == tti_pkg::S_MD_WAIT, "stray divide done")

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BITS = tti_pkg::TIME_BITS;
  localparam int COORD_BITS = tti_pkg::COORD_BITS;
  localparam int TABLE_DEPTH = tti_pkg::MAX_POINTS_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT_ITEM = 60;
  localparam int RANDOM_ITEMS = 1330;

  localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // idle mix: receiver-heavy, sender-heavy, none
  typedef enum int {MIX_RX_SLOW, MIX_TX_SLOW, MIX_FULL_RATE} mix_t;

  typedef struct {
    tti_pkg::op_t                 op;
    logic signed [TIME_BITS-1:0]  t;
    logic signed [COORD_BITS-1:0] x, y, z;
    mix_t                         mix;
  } path_item_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x, y, z;
    tti_pkg::status_t             status;
    logic                         span;
    logic signed [COORD_BITS-1:0] lo [3];
    logic signed [COORD_BITS-1:0] hi [3];
  } position_t;

  typedef struct {
    logic signed [TIME_BITS-1:0]  t;
    logic signed [COORD_BITS-1:0] c [3];
  } path_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [TIME_BITS-1:0] in_sample_time = '0;
  logic signed [COORD_BITS-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [COORD_BITS-1:0] out_x, out_y, out_z;
  logic [2:0] out_status;
  logic out_in_span;
  logic signed [COORD_BITS-1:0] out_box_min_x, out_box_min_y, out_box_min_z;
  logic signed [COORD_BITS-1:0] out_box_max_x, out_box_max_y, out_box_max_z;

  trajectory_time_interpolator dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Path table shadow: sorted by time, equal times keep arrival order
  // ---------------------------------------------------------------
  path_point_t path_pts[$];
  logic signed [TIME_BITS-1:0] span_lo = T_MAX, span_hi = T_MIN;
  logic signed [COORD_BITS-1:0] corner_lo [3] = '{C_MAX, C_MAX, C_MAX};
  logic signed [COORD_BITS-1:0] corner_hi [3] = '{C_MIN, C_MIN, C_MIN};

  path_item_t pending_items[$];
  position_t expected_positions[$];
  logic signed [TIME_BITS-1:0] added_times[$];

  int mismatches = 0;
  int accepted_items = 0;
  int cycles = 0;
  mix_t rx_mix = MIX_RX_SLOW;

  // first index whose time is strictly later than t
  function automatic int first_later(logic signed [TIME_BITS-1:0] t);
    int lo_i, hi_i, mid;
    lo_i = 0;
    hi_i = path_pts.size();
    while (lo_i < hi_i) begin
      mid = (lo_i + hi_i) / 2;
      if (path_pts[mid].t > t) hi_i = mid;
      else lo_i = mid + 1;
    end
    return lo_i;
  endfunction

  // p0 + (p1-p0)*num/den, step truncated toward zero, exact wide product
  function automatic logic signed [COORD_BITS-1:0] blend(
      logic signed [COORD_BITS-1:0] p0, logic signed [COORD_BITS-1:0] p1,
      logic [TIME_BITS:0] num, logic [TIME_BITS:0] den);
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0] mag;
    logic [127:0] step;
    diff = {p1[COORD_BITS-1], p1} - {p0[COORD_BITS-1], p0};
    mag = diff[COORD_BITS] ? -diff : diff;
    step = (128'(mag) * 128'(num)) / 128'(den);
    return diff[COORD_BITS] ? p0 - step[COORD_BITS-1:0] : p0 + step[COORD_BITS-1:0];
  endfunction

  // apply one item to the shadow table and return the position it reports
  function automatic position_t track_path(path_item_t it);
    position_t r;
    path_point_t p, a, b;
    int i;
    logic [TIME_BITS:0] num, den;
    r.x = '0; r.y = '0; r.z = '0;
    r.span = 1'b0;
    if (it.op == tti_pkg::OP_ADD) begin
      if (path_pts.size() >= TABLE_DEPTH) begin
        r.status = tti_pkg::ST_FULL;
      end else begin
        p.t = it.t;
        p.c[0] = it.x; p.c[1] = it.y; p.c[2] = it.z;
        path_pts.insert(first_later(it.t), p);
        for (int k = 0; k < 3; k++) begin
          if (p.c[k] < corner_lo[k]) corner_lo[k] = p.c[k];
          if (p.c[k] > corner_hi[k]) corner_hi[k] = p.c[k];
        end
        if (it.t < span_lo) span_lo = it.t;
        if (it.t > span_hi) span_hi = it.t;
        r.status = tti_pkg::ST_STORED;
      end
    end else begin
      r.span = (it.t >= span_lo) && (it.t <= span_hi);
      if (path_pts.size() == 0) begin
        r.status = tti_pkg::ST_EMPTY;
      end else begin
        i = first_later(it.t);
        if (i == 0 || i >= path_pts.size()) begin
          a = (i == 0) ? path_pts[0] : path_pts[path_pts.size()-1];
          r.x = a.c[0]; r.y = a.c[1]; r.z = a.c[2];
          r.status = (i == 0) ? tti_pkg::ST_BEFORE : tti_pkg::ST_AFTER;
        end else begin
          a = path_pts[i-1];
          b = path_pts[i];
          num = {it.t[TIME_BITS-1], it.t} - {a.t[TIME_BITS-1], a.t};
          den = {b.t[TIME_BITS-1], b.t} - {a.t[TIME_BITS-1], a.t};
          r.x = blend(a.c[0], b.c[0], num, den);
          r.y = blend(a.c[1], b.c[1], num, den);
          r.z = blend(a.c[2], b.c[2], num, den);
          r.status = tti_pkg::ST_INTERP;
        end
      end
    end
    r.lo = corner_lo;
    r.hi = corner_hi;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Driver: accept at posedge, present next item at negedge
  // ---------------------------------------------------------------
  logic took = 1'b0;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_positions.push_back(track_path(pending_items[0]));
      void'(pending_items.pop_front());
      accepted_items++;
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (pending_items.size() > 0 &&
          !(pending_items[0].mix == MIX_RX_SLOW && $urandom_range(99) < 35) &&
          !(pending_items[0].mix == MIX_TX_SLOW && $urandom_range(99) < 61)) begin
        in_valid <= 1'b1;
        in_opcode <= pending_items[0].op;
        in_sample_time <= pending_items[0].t;
        in_pos_x <= pending_items[0].x;
        in_pos_y <= pending_items[0].y;
        in_pos_z <= pending_items[0].z;
        rx_mix <= pending_items[0].mix;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Receiver stall, with one long hold-off so the block backs up
  // ---------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (rx_mix)
        MIX_RX_SLOW: out_stall <= ($urandom_range(99) < 61);
        MIX_TX_SLOW: out_stall <= ($urandom_range(99) < 35);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Monitor: compare every result with the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    position_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", out_status);
      end else begin
        e = expected_positions.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
            out_status !== e.status || out_in_span !== e.span ||
            out_box_min_x !== e.lo[0] || out_box_min_y !== e.lo[1] ||
            out_box_min_z !== e.lo[2] || out_box_max_x !== e.hi[0] ||
            out_box_max_y !== e.hi[1] || out_box_max_z !== e.hi[2]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp xyz %0d %0d %0d st %0d span %0d", e.x, e.y, e.z,
                     e.status, e.span);
            $display("          got xyz %0d %0d %0d st %0d span %0d", out_x, out_y,
                     out_z, out_status, out_in_span);
            $display("  box exp %0d %0d %0d / %0d %0d %0d", e.lo[0], e.lo[1], e.lo[2],
                     e.hi[0], e.hi[1], e.hi[2]);
            $display("  box got %0d %0d %0d / %0d %0d %0d", out_box_min_x,
                     out_box_min_y, out_box_min_z, out_box_max_x, out_box_max_y,
                     out_box_max_z);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  mix_t gen_mix = MIX_RX_SLOW;

  task automatic queue_item(tti_pkg::op_t op, logic signed [TIME_BITS-1:0] t,
                            logic signed [COORD_BITS-1:0] x = '0,
                            logic signed [COORD_BITS-1:0] y = '0,
                            logic signed [COORD_BITS-1:0] z = '0);
    path_item_t it;
    it.op = op; it.t = t; it.x = x; it.y = y; it.z = z; it.mix = gen_mix;
    pending_items.push_back(it);
    if (op == tti_pkg::OP_ADD) added_times.push_back(t);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(1)) return $urandom;
    return $signed($urandom_range(2000)) - 1000;
  endfunction

  // mostly a narrow window so queries land between points; rarely full range
  function automatic logic signed [TIME_BITS-1:0] pick_time(bit for_query);
    int r;
    r = $urandom_range(99);
    if (r < 6) return TIME_BITS'({$urandom, $urandom});
    if (for_query && r < 30 && added_times.size() > 0)
      return added_times[$urandom_range(added_times.size() - 1)];
    return $signed(TIME_BITS'($urandom_range(200000))) - 50000;
  endfunction

  initial begin
    // empty table, box at reset values
    queue_item(tti_pkg::OP_QUERY, 0);
    queue_item(tti_pkg::OP_QUERY, T_MAX);
    queue_item(tti_pkg::OP_ADD, 100, C_MAX, C_MIN, 0);
    queue_item(tti_pkg::OP_QUERY, 50);                 // before first
    queue_item(tti_pkg::OP_QUERY, 100);                // exactly on the only point
    queue_item(tti_pkg::OP_ADD, 200, C_MIN, C_MAX, -1);
    queue_item(tti_pkg::OP_QUERY, 150);                // full-scale swing
    queue_item(tti_pkg::OP_QUERY, 101);
    queue_item(tti_pkg::OP_QUERY, 199);
    queue_item(tti_pkg::OP_ADD, 200, 5, -5, 7);        // equal time goes after
    queue_item(tti_pkg::OP_QUERY, 200);
    queue_item(tti_pkg::OP_QUERY, 199);
    queue_item(tti_pkg::OP_ADD, T_MIN, -3, 3, C_MAX);
    queue_item(tti_pkg::OP_ADD, T_MAX, 11, C_MIN, C_MIN);
    queue_item(tti_pkg::OP_QUERY, T_MIN);
    queue_item(tti_pkg::OP_QUERY, T_MAX);
    queue_item(tti_pkg::OP_QUERY, 0);
    queue_item(tti_pkg::OP_QUERY, T_MAX - 1);
    queue_item(tti_pkg::OP_QUERY, T_MIN + 1);
    queue_item(tti_pkg::OP_QUERY, 250);

    // random: mostly queries against a growing table, three idle phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS / 3) gen_mix = MIX_RX_SLOW;
      else if (n < 2 * RANDOM_ITEMS / 3) gen_mix = MIX_TX_SLOW;
      else gen_mix = MIX_FULL_RATE;
      if ($urandom_range(99) < 12)
        queue_item(tti_pkg::OP_ADD, pick_time(1'b0), pick_coord(), pick_coord(),
                   pick_coord());
      else
        queue_item(tti_pkg::OP_QUERY, pick_time(1'b1));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0 && expected_positions.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_positions.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
